/* hdl/rgb_box_filter_3x3_macros.svh */
// Assertion macros used by the checker file of the 3x3 box filter.
`ifndef RGB_BOX_FILTER_3X3_MACROS_SVH
`define RGB_BOX_FILTER_3X3_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define RBF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal holds its value in the cycle after the condition.
`define RBF_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("signal changed while held");

`endif

/* hdl/rbf_pkg.sv */
// Shared types and constants of the RGB 3x3 box filter.
`default_nettype none

package rbf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// size register width and reply coordinate width are fixed by the interface
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int POS_W     = 8;
	localparam int PIX_W     = 8;
	localparam int NCH       = 3;
	localparam int WIN_N     = 3;

	// compare widths for the clamped frame size against the counters
	localparam int WCMP_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int HCMP_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

	// mean = (sum + 4) / 9, exact for sums up to 2299 via (x * 3641) >> 15
	localparam int SUM_W       = 12;
	localparam int ROUND_BIAS  = 4;
	localparam int RECIP_W     = 12;
	localparam int RECIP       = 3641;
	localparam int RECIP_SHIFT = 15;

	// channel order in a packed pixel: index 2 red, 1 green, 0 blue
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] chan_t;
	typedef logic [NCH-1:0][PIX_W-1:0] px_t;

	typedef struct packed {
		px_t upper;
		px_t middle;
	} ls_entry_t;

	localparam int LS_W = $bits(ls_entry_t);

	typedef struct packed {
		logic             last;
		logic [POS_W-1:0] crow;
		logic [POS_W-1:0] ccol;
	} meta_t;

	typedef struct packed {
		px_t   px;
		meta_t meta;
	} res_t;

endpackage

`default_nettype wire

/* hdl/rbf_line_store.sv */
// Line store RAM: the two previous rows, one entry per column.
`default_nettype none

module rbf_line_store (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [rbf_pkg::COL_W-1:0] rd_addr,
	output logic [rbf_pkg::LS_W-1:0]  rd_data_q,
	input  logic                      wr_en,
	input  logic [rbf_pkg::COL_W-1:0] wr_addr,
	input  logic [rbf_pkg::LS_W-1:0]  wr_data
);
	import rbf_pkg::*;

	logic [LS_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/rbf_lane.sv */
// One colour lane: 3x3 window, nine-sample sum and rounded mean.
`default_nettype none

module rbf_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                shift,
	input  rbf_pkg::chan_t      up,
	input  rbf_pkg::chan_t      mid,
	input  rbf_pkg::chan_t      pix,
	output rbf_pkg::chan_t      mean
);
	import rbf_pkg::*;

	// win_q[row][col], row 0 is the oldest line, col 2 the newest pixel
	logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] win_q;
	logic [SUM_W-1:0]                       sum;
	logic [SUM_W-1:0]                       sum_s3;
	logic [SUM_W+RECIP_W-1:0]               prod;
	chan_t                                  mean_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			for (int k = 0; k < WIN_N; k++) begin
				for (int j = 0; j < WIN_N - 1; j++) begin
					win_q[k][j] <= win_q[k][j+1];
				end
			end
			win_q[0][WIN_N-1] <= up;
			win_q[1][WIN_N-1] <= mid;
			win_q[2][WIN_N-1] <= pix;
		end
	end

	always_comb begin
		sum = SUM_W'(ROUND_BIAS);
		for (int k = 0; k < WIN_N; k++) begin
			for (int j = 0; j < WIN_N; j++) begin
				sum = sum + SUM_W'(win_q[k][j]);
			end
		end
	end

	assign prod = (SUM_W + RECIP_W)'(sum_s3) * (SUM_W + RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum;
			mean_s4 <= prod[RECIP_SHIFT +: PIX_W];
		end
	end

	assign mean = mean_s4;

endmodule

`default_nettype wire

/* hdl/rgb_box_filter_3x3.sv */
// Top level of the RGB 3x3 box filter: counters, line store, three lanes, output skid.
// One pixel per clock while not stalled; line store has one read and one write port,
// bypassed on a clash. A result moves from its pixel's transaction, on which s1 loads,
// through s2 to s4 into the output register; a stalled output fills a one-entry skid,
// which raises in_stall.
// Reset clears counters, windows, valids and skid, and sets both frame sizes to 256;
// the line store is not cleared and needs no clearing pass.
`default_nettype none

module rgb_box_filter_3x3 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [rbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rbf_pkg::PIX_W-1:0]     red_in,
	input  logic [rbf_pkg::PIX_W-1:0]     green_in,
	input  logic [rbf_pkg::PIX_W-1:0]     blue_in,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rbf_pkg::PIX_W-1:0]     red_out,
	output logic [rbf_pkg::PIX_W-1:0]     green_out,
	output logic [rbf_pkg::PIX_W-1:0]     blue_out,
	output logic [rbf_pkg::POS_W-1:0]     centre_row,
	output logic [rbf_pkg::POS_W-1:0]     centre_col,
	output logic                          frame_last
);
	import rbf_pkg::*;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic              accept, en;
	logic [WCMP_W-1:0] w_cfg, w_eff, c0, c1, cn;
	logic [HCMP_W-1:0] h_cfg, h_eff, r0, r1, r2, rn, rn_w, crow_full;
	logic [WCMP_W-1:0] ccol_full;
	logic              wrap0, wrap1, emit;
	logic [COL_W-1:0]  col_cur;
	px_t               pix;
	meta_t             meta_cur;

	logic              v_s1, emit_s1, byp_s1;
	logic [COL_W-1:0]  col_s1;
	px_t               pix_s1;
	meta_t             meta_s1;
	ls_entry_t         bypd_s1;
	logic              v_s2, v_s3, v_s4;
	meta_t             meta_s2, meta_s3, meta_s4;

	logic [LS_W-1:0]   rd_data_q;
	ls_entry_t         ent;
	ls_entry_t         wr_ent;

	px_t               mean_px;
	res_t              res;
	res_t              out_q, skid_q;
	logic              out_valid_q, skid_full_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(MAX_WIDTH);
			height_q <= CFG_W'(MAX_HEIGHT);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;
	assign accept   = in_valid && !skid_full_q;

	// position of the incoming pixel, with clamped sizes
	always_comb begin
		w_cfg = WCMP_W'(width_q);
		h_cfg = HCMP_W'(height_q);
		if (w_cfg < WCMP_W'(3))
			w_eff = WCMP_W'(3);
		else if (w_cfg > WCMP_W'(MAX_WIDTH))
			w_eff = WCMP_W'(MAX_WIDTH);
		else
			w_eff = w_cfg;
		if (h_cfg < HCMP_W'(3))
			h_eff = HCMP_W'(3);
		else if (h_cfg > HCMP_W'(MAX_HEIGHT))
			h_eff = HCMP_W'(MAX_HEIGHT);
		else
			h_eff = h_cfg;

		c0    = frame_start ? '0 : WCMP_W'(col_q);
		r0    = frame_start ? '0 : HCMP_W'(row_q);
		// size shrunk under the counters: move on a row, or to row 0
		wrap0 = c0 >= w_eff;
		c1    = wrap0 ? '0 : c0;
		r1    = wrap0 ? r0 + HCMP_W'(1) : r0;
		r2    = (r1 >= h_eff) ? '0 : r1;

		cn    = c1 + WCMP_W'(1);
		wrap1 = cn >= w_eff;
		rn    = r2 + HCMP_W'(1);
		rn_w  = (rn >= h_eff) ? '0 : rn;

		col_cur   = c1[COL_W-1:0];
		emit      = (r2 >= HCMP_W'(2)) && (c1 >= WCMP_W'(2));
		crow_full = r2 - HCMP_W'(1);
		ccol_full = c1 - WCMP_W'(1);
		meta_cur.crow = crow_full[POS_W-1:0];
		meta_cur.ccol = ccol_full[POS_W-1:0];
		meta_cur.last = (r2 == h_eff - HCMP_W'(1)) && (c1 == w_eff - WCMP_W'(1));

		pix[CH_RED]   = red_in;
		pix[CH_GREEN] = green_in;
		pix[CH_BLUE]  = blue_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= wrap1 ? '0 : cn[COL_W-1:0];
			row_q <= wrap1 ? rn_w[ROW_W-1:0] : r2[ROW_W-1:0];
		end
	end

	// line store: read on transaction, write back from s1 while not stalled
	rbf_line_store u_line_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (col_cur),
		.rd_data_q (rd_data_q),
		.wr_en     (en && v_s1),
		.wr_addr   (col_s1),
		.wr_data   (wr_ent)
	);

	assign ent           = byp_s1 ? bypd_s1 : ls_entry_t'(rd_data_q);
	assign wr_ent.upper  = ent.middle;
	assign wr_ent.middle = pix_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (accept) begin
				col_s1  <= col_cur;
				pix_s1  <= pix;
				emit_s1 <= emit;
				meta_s1 <= meta_cur;
				// same column being written back this edge: take the fresh entry
				byp_s1  <= v_s1 && (col_s1 == col_cur);
				bypd_s1 <= wr_ent;
			end
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
		end
	end

	for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
		rbf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shift  (en && v_s1),
			.up     (ent.upper[ch]),
			.mid    (ent.middle[ch]),
			.pix    (pix_s1[ch]),
			.mean   (mean_px[ch])
		);
	end

	assign res.px   = mean_px;
	assign res.meta = meta_s4;

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall)
				skid_full_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= v_s4;
		end else if (v_s4) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!out_stall)
				out_q <= skid_q;
		end else if (!out_valid_q || !out_stall) begin
			if (v_s4)
				out_q <= res;
		end else if (v_s4) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = out_q.px[CH_RED];
	assign green_out  = out_q.px[CH_GREEN];
	assign blue_out   = out_q.px[CH_BLUE];
	assign centre_row = out_q.meta.crow;
	assign centre_col = out_q.meta.ccol;
	assign frame_last = out_q.meta.last;

endmodule

`default_nettype wire

/* hdl/rbf_checker.sv */
// Port-level checks of the RGB 3x3 box filter and their binding to the top level.
`default_nettype none

`include "rgb_box_filter_3x3_macros.svh"

module rbf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [rbf_pkg::PIX_W-1:0]     red_out,
	input  logic [rbf_pkg::PIX_W-1:0]     green_out,
	input  logic [rbf_pkg::PIX_W-1:0]     blue_out,
	input  logic [rbf_pkg::POS_W-1:0]     centre_row,
	input  logic [rbf_pkg::POS_W-1:0]     centre_col,
	input  logic                          frame_last
);
	import rbf_pkg::*;

	// a stalled transaction keeps its payload
	`RBF_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(centre_row) && $stable(centre_col), "stalled result changed")
	`RBF_ASSERT_HOLD(a_last_hold, clk, arst_n, out_valid && out_stall, frame_last)

	// skid fills only behind a stalled output, and drains as soon as it is taken
	`RBF_ASSERT(a_skid_fill, clk, arst_n, $rose(in_stall) |-> $past(out_valid && out_stall), "input stalled without output back-pressure")
	`RBF_ASSERT(a_skid_drain, clk, arst_n, in_stall && !out_stall |=> !in_stall, "skid did not drain")

	// centres on row or column 0 or 255 never leave the block
	`RBF_ASSERT(a_no_border, clk, arst_n, out_valid |-> centre_row != 8'd0 && centre_row != 8'd255 && centre_col != 8'd0 && centre_col != 8'd255, "border pixel emitted")

endmodule

bind rgb_box_filter_3x3 rbf_checker u_rbf_checker (.*);

`default_nettype wire
